// ----- design/assert_macros.svh -----
// Assertion macros shared by the engine RTL.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/hidce_pkg.sv -----
// Types and constants of the HID command engine.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hidce_pkg;
  localparam logic [3:0] ActTick = 4'd0;
  localparam logic [3:0] ActKeyDown = 4'd1;
  localparam logic [3:0] ActKeyUp = 4'd2;
  localparam logic [3:0] ActSetMod = 4'd3;
  localparam logic [3:0] ActMove = 4'd4;
  localparam logic [3:0] ActButton = 4'd5;
  localparam logic [3:0] ActWheel = 4'd6;
  localparam logic [3:0] ActRecBegin = 4'd7;
  localparam logic [3:0] ActRecEvent = 4'd8;
  localparam logic [3:0] ActRecEnd = 4'd9;
  localparam logic [3:0] ActCancel = 4'd10;
  localparam logic [3:0] ActPing = 4'd11;
  localparam logic [3:0] ActReport = 4'd12;

  localparam logic [1:0] EvKeyDown = 2'd0;
  localparam logic [1:0] EvKeyUp = 2'd1;
  localparam logic [1:0] EvSetMod = 2'd2;

  localparam logic [1:0] RepNone = 2'd0;
  localparam logic [1:0] RepKeyboard = 2'd1;
  localparam logic [1:0] RepMouse = 2'd2;
  localparam logic [1:0] RepPong = 2'd3;

  localparam int unsigned EventWidth = 26;
  localparam int unsigned ReportSlots = 6;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] time_ms;
    logic [7:0]  key_code;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  wheel_step;
    logic        button_press;
    logic        loop_playback;
    logic [15:0] event_offset_ms;
    logic [1:0]  event_kind;
    logic [15:0] ping_value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [7:0]  report_modifiers;
    logic [47:0] report_keys;
    logic [7:0]  report_buttons;
    logic signed [7:0] report_x;
    logic signed [7:0] report_y;
    logic signed [7:0] report_wheel;
    logic [15:0] report_nonce;
  } report_word_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else sat_add = s[31:0];
  endfunction

  function automatic logic signed [7:0] clamp127(input logic signed [31:0] v);
    if (v > 32'sd127) clamp127 = 8'sd127;
    else if (v < -32'sd127) clamp127 = -8'sd127;
    else clamp127 = v[7:0];
  endfunction
endpackage
`default_nettype wire

// ----- design/hid_input_command_engine_top.sv -----
// Top level of the HID command engine: keyboard, mouse, macro playback, watchdog.
// Depends on hidce_pkg, hidce_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//
//  channel  direction  handshake               word
//  cmd      in         cmd_valid_i/cmd_stall_o  hidce_pkg::cmd_word_t
//  rep      out        rep_valid_o/rep_stall_i  hidce_pkg::report_word_t
//  cfg      in         cfg_we_i                 16-bit watchdog timeout
//
// A command word is taken in StIdle and run in StExec; a tick also passes through StRead
// and StApply for each stored event it reads (each due event, and the first not yet due).
// Every word yields exactly one report word in an output register. A held-back report
// stalls the command input, and the next command is taken at the earliest on the edge
// that takes that report.
// Reset clears all control state; event memory contents are not cleared, and
// playback only reads entries written since recording began.
module hid_input_command_engine_top #(
  parameter int unsigned KeySlots = 6,
  parameter int unsigned EventDepth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_valid_i,
  output logic                          cmd_stall_o,
  input  wire hidce_pkg::cmd_word_t     cmd_word_i,
  output logic                          rep_valid_o,
  input  wire logic                     rep_stall_i,
  output hidce_pkg::report_word_t       rep_word_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [15:0]              cfg_wdata_i
);
  localparam int unsigned AddrW = $clog2(EventDepth);
  localparam int unsigned CntW = AddrW + 1;

  // Sequencer codes.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StApply = 2'd3;

  logic [1:0] state_q, state_d;
  hidce_pkg::cmd_word_t cmd_q, cmd_d;

  logic [15:0] timeout_q;
  logic [7:0]  slots_q [KeySlots];
  logic [7:0]  slots_d [KeySlots];
  logic [7:0]  mod_q, mod_d, btn_q, btn_d;
  logic        kbd_chg_q, kbd_chg_d, mouse_chg_q, mouse_chg_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pw_q, pw_d;
  logic        pong_q, pong_d;
  logic [15:0] pong_val_q, pong_val_d;
  logic [31:0] last_q, last_d;
  logic [CntW-1:0] count_q, count_d, pidx_q, pidx_d;
  logic [31:0] pstart_q, pstart_d;
  logic        rec_q, rec_d, loop_q, loop_d, act_q, act_d;
  logic        rep_valid_q, rep_valid_d;
  hidce_pkg::report_word_t rep_q, rep_d;

  logic        we;
  logic [AddrW-1:0] waddr;
  logic [hidce_pkg::EventWidth-1:0] wdata, rdata;

  hidce_ram #(.Width(hidce_pkg::EventWidth), .Depth(EventDepth)) u_events (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(pidx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  assign cmd_stall_o = (state_q != StIdle) || (rep_valid_q && rep_stall_i);
  assign rep_valid_o = rep_valid_q;
  assign rep_word_o  = rep_q;

  logic [31:0] elapsed;
  assign elapsed = cmd_q.time_ms - pstart_q;

  // The event at pidx is due only if its offset has passed; the read data
  // arrives in StApply, so an event that is not yet due ends the tick there.
  logic apply_due;
  assign apply_due = {16'd0, rdata[15:0]} <= elapsed;

  always_comb begin
    logic found, placed;
    logic [7:0] code;
    logic [3:0] op;
    logic [47:0] keys;
    logic signed [7:0] dx, dy, dw;
    logic signed [31:0] nx, ny, nw;
    logic finish;
    state_d = state_q; cmd_d = cmd_q;
    slots_d = slots_q; mod_d = mod_q; btn_d = btn_q;
    kbd_chg_d = kbd_chg_q; mouse_chg_d = mouse_chg_q;
    px_d = px_q; py_d = py_q; pw_d = pw_q;
    pong_d = pong_q; pong_val_d = pong_val_q; last_d = last_q;
    count_d = count_q; pidx_d = pidx_q; pstart_d = pstart_q;
    rec_d = rec_q; loop_d = loop_q; act_d = act_q;
    rep_valid_d = rep_valid_q && rep_stall_i; rep_d = rep_q;
    we = 1'b0; waddr = count_q[AddrW-1:0];
    wdata = {cmd_q.key_code, cmd_q.event_kind, cmd_q.event_offset_ms};
    found = 1'b0; placed = 1'b0; finish = 1'b0;
    code = cmd_q.key_code; op = cmd_q.action;
    keys = '0; dx = '0; dy = '0; dw = '0; nx = '0; ny = '0; nw = '0;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && !cmd_stall_o) begin
          cmd_d = cmd_word_i;
          state_d = StExec;
        end
      end
      StRead: state_d = StApply;
      default: begin
        // StExec runs the command; StApply applies one stored event.
        finish = 1'b1;
        if (state_q == StApply) begin
          op = hidce_pkg::ActTick;
          if (apply_due) begin
            code = rdata[25:18];
            unique case (rdata[17:16])
              hidce_pkg::EvKeyDown: op = hidce_pkg::ActKeyDown;
              hidce_pkg::EvKeyUp: op = hidce_pkg::ActKeyUp;
              hidce_pkg::EvSetMod: op = hidce_pkg::ActSetMod;
              default: ;
            endcase
            pidx_d = pidx_q + CntW'(1);
          end
        end else if (cmd_q.action >= hidce_pkg::ActKeyDown &&
                     cmd_q.action <= hidce_pkg::ActPing) begin
          last_d = cmd_q.time_ms;
        end
        if (state_q == StApply || op == hidce_pkg::ActKeyDown ||
            op == hidce_pkg::ActKeyUp || op == hidce_pkg::ActSetMod) begin
          unique case (op)
            hidce_pkg::ActKeyDown: begin
              for (int i = 0; i < KeySlots; i++) if (slots_q[i] == code) found = 1'b1;
              if (code != 8'd0 && !found) begin
                for (int i = 0; i < KeySlots; i++) begin
                  if (!placed && slots_q[i] == 8'd0) begin
                    slots_d[i] = code; placed = 1'b1;
                  end
                end
                if (!placed) slots_d[0] = code;
                kbd_chg_d = 1'b1;
              end
            end
            hidce_pkg::ActKeyUp: begin
              for (int i = 0; i < KeySlots; i++) begin
                if (slots_q[i] == code) begin
                  slots_d[i] = 8'd0; kbd_chg_d = 1'b1;
                end
              end
            end
            hidce_pkg::ActSetMod: begin mod_d = code; kbd_chg_d = 1'b1; end
            default: ;
          endcase
        end else begin
          unique case (cmd_q.action)
            hidce_pkg::ActTick: begin
              // Fetch the next stored event if playback is active and one remains, else finish the tick.
              if (act_q && pidx_q < count_q && pidx_q < CntW'(EventDepth) &&
                  state_q == StExec) begin
                state_d = StRead; finish = 1'b0;
              end
            end
            hidce_pkg::ActMove: begin
              px_d = hidce_pkg::sat_add(px_q, 32'(cmd_q.move_x));
              py_d = hidce_pkg::sat_add(py_q, 32'(cmd_q.move_y));
              mouse_chg_d = 1'b1;
            end
            hidce_pkg::ActButton: begin
              btn_d = cmd_q.button_press ? (btn_q | code) : (btn_q & ~code);
              mouse_chg_d = 1'b1;
            end
            hidce_pkg::ActWheel: begin
              pw_d = hidce_pkg::sat_add(pw_q, 32'(cmd_q.wheel_step));
              mouse_chg_d = 1'b1;
            end
            hidce_pkg::ActRecBegin: begin
              rec_d = 1'b1; loop_d = cmd_q.loop_playback; act_d = 1'b0; count_d = '0;
            end
            hidce_pkg::ActRecEvent: begin
              if (rec_q && count_q < CntW'(EventDepth)) begin
                we = 1'b1; count_d = count_q + CntW'(1);
              end
            end
            hidce_pkg::ActRecEnd: begin
              rec_d = 1'b0;
              if (count_q != '0) begin
                act_d = 1'b1; pidx_d = '0; pstart_d = cmd_q.time_ms;
              end
            end
            hidce_pkg::ActCancel: begin
              rec_d = 1'b0; act_d = 1'b0; count_d = '0;
              mod_d = '0; btn_d = '0; kbd_chg_d = 1'b1; mouse_chg_d = 1'b1;
              px_d = '0; py_d = '0; pw_d = '0;
              for (int i = 0; i < KeySlots; i++) slots_d[i] = '0;
            end
            hidce_pkg::ActPing: begin pong_d = 1'b1; pong_val_d = cmd_q.ping_value; end
            hidce_pkg::ActReport: begin
              rep_d = '0;
              if (pong_q) begin
                rep_d.report_kind = hidce_pkg::RepPong; rep_d.report_nonce = pong_val_q;
                pong_d = 1'b0;
              end else if (kbd_chg_q) begin
                for (int i = 0; i < hidce_pkg::ReportSlots; i++)
                  if (i < KeySlots) keys[8*i +: 8] = slots_q[i];
                rep_d.report_kind = hidce_pkg::RepKeyboard;
                rep_d.report_modifiers = mod_q; rep_d.report_keys = keys;
                kbd_chg_d = 1'b0;
              end else if (mouse_chg_q) begin
                dx = hidce_pkg::clamp127(px_q); dy = hidce_pkg::clamp127(py_q);
                dw = hidce_pkg::clamp127(pw_q);
                nx = px_q - 32'(dx); ny = py_q - 32'(dy); nw = pw_q - 32'(dw);
                px_d = nx; py_d = ny; pw_d = nw;
                rep_d.report_kind = hidce_pkg::RepMouse; rep_d.report_buttons = btn_q;
                rep_d.report_x = dx; rep_d.report_y = dy; rep_d.report_wheel = dw;
                if (nx == 0 && ny == 0 && nw == 0) mouse_chg_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        // A tick in StApply continues with the next event if there is one.
        if (state_q == StApply && apply_due) begin
          if (pidx_d < count_q && pidx_d < CntW'(EventDepth)) begin
            state_d = StRead; finish = 1'b0;
          end
        end
      end
    endcase

    if (finish) begin
      state_d = StIdle;
      rep_valid_d = 1'b1;
      if (cmd_q.action != hidce_pkg::ActReport) rep_d = '0;
    end
  end

  // Final tick bookkeeping (loop/stop, then watchdog) from the values that
  // the event loop leaves behind.
  logic [7:0]  slots_f [KeySlots];
  logic [7:0]  mod_f;
  logic        kbd_f, mouse_f, act_f, rec_f;
  logic [CntW-1:0] pidx_f, count_f;
  logic [31:0] pstart_f, last_f;
  logic [7:0]  btn_f;
  logic signed [31:0] px_f, py_f, pw_f;
  logic [1:0]  state_f;
  always_comb begin
    logic tick_end, any_held;
    slots_f = slots_d; mod_f = mod_d; kbd_f = kbd_chg_d; mouse_f = mouse_chg_d;
    act_f = act_d; rec_f = rec_d; pidx_f = pidx_d; count_f = count_d;
    pstart_f = pstart_d; last_f = last_d; btn_f = btn_d;
    px_f = px_d; py_f = py_d; pw_f = pw_d; state_f = state_d;
    any_held = 1'b0;
    tick_end = (cmd_q.action == hidce_pkg::ActTick) &&
               (state_q == StExec || state_q == StApply) && (state_d == StIdle);
    if (tick_end) begin
      if (act_q && pidx_f >= count_q) begin
        if (loop_q) begin pidx_f = '0; pstart_f = cmd_q.time_ms; end
        else act_f = 1'b0;
      end
      if (cmd_q.time_ms - last_q > 32'(timeout_q)) begin
        any_held = (mod_f != 8'd0) || (btn_q != 8'd0);
        for (int i = 0; i < KeySlots; i++) if (slots_f[i] != 8'd0) any_held = 1'b1;
        if (any_held || act_f) begin
          rec_f = 1'b0; act_f = 1'b0; count_f = '0;
          mod_f = '0; btn_f = '0; kbd_f = 1'b1; mouse_f = 1'b1;
          px_f = '0; py_f = '0; pw_f = '0;
          for (int i = 0; i < KeySlots; i++) slots_f[i] = '0;
        end
        last_f = cmd_q.time_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; timeout_q <= 16'd2000;
      for (int i = 0; i < KeySlots; i++) slots_q[i] <= '0;
      mod_q <= '0; btn_q <= '0; kbd_chg_q <= 1'b0; mouse_chg_q <= 1'b0;
      px_q <= '0; py_q <= '0; pw_q <= '0; pong_q <= 1'b0; pong_val_q <= '0;
      last_q <= '0; count_q <= '0; pidx_q <= '0; pstart_q <= '0;
      rec_q <= 1'b0; loop_q <= 1'b0; act_q <= 1'b0; rep_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      state_q <= state_f; slots_q <= slots_f; mod_q <= mod_f; btn_q <= btn_f;
      kbd_chg_q <= kbd_f; mouse_chg_q <= mouse_f;
      px_q <= px_f; py_q <= py_f; pw_q <= pw_f;
      pong_q <= pong_d; pong_val_q <= pong_val_d; last_q <= last_f;
      count_q <= count_f; pidx_q <= pidx_f; pstart_q <= pstart_f;
      rec_q <= rec_f; loop_q <= loop_d; act_q <= act_f;
      rep_valid_q <= rep_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rep_q <= rep_d;
  end

  `ASSERT_IMPL(a_rec_not_play, clk_i, rst_ni, rec_q, !act_q)
  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(EventDepth))
  `ASSERT_IMPL(a_idx_bound, clk_i, rst_ni, act_q, pidx_q <= count_q)
  `ASSERT_NEXT(a_busy_stall, clk_i, rst_ni, cmd_valid_i && !cmd_stall_o, cmd_stall_o)
endmodule
`default_nettype wire

// ----- design/hidce_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module hidce_ram #(
  parameter int unsigned Width = 26,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- dv/hidce_checker.sv -----
// Checker for the HID command engine: watches both channels, predicts reports, compares.
// Depends on hidce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hidce_checker (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  wire logic                  cmd_stall_i,
  input  wire hidce_pkg::cmd_word_t  cmd_word_i,
  input  wire logic                  rep_valid_i,
  input  wire logic                  rep_stall_i,
  input  wire hidce_pkg::report_word_t rep_word_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [15:0]           cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         report_count_o
);
  logic [15:0] wd_timeout;
  logic [7:0] slots [6];
  logic [7:0] mods, buttons;
  logic kbd_changed, mouse_changed, pong_due;
  logic [15:0] pong_saved;
  logic signed [31:0] sum_x, sum_y, sum_w;
  logic [31:0] last_feed_ms, start_ms;
  logic [25:0] macro_mem [256];
  int unsigned macro_len, macro_pos;
  logic recording, looping, playing;
  hidce_pkg::report_word_t expected_reports [$];

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
    if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] limit127(logic signed [31:0] v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  task automatic press(logic [7:0] code);
    if (code == 0) return;
    foreach (slots[i]) if (slots[i] == code) return;
    foreach (slots[i]) if (slots[i] == 0) begin
      slots[i] = code;
      kbd_changed = 1;
      return;
    end
    slots[0] = code;
    kbd_changed = 1;
  endtask

  task automatic lift(logic [7:0] code);
    foreach (slots[i]) if (slots[i] == code) begin
      slots[i] = 0;
      kbd_changed = 1;
    end
  endtask

  task automatic drop_everything();
    mods = 0;
    foreach (slots[i]) slots[i] = 0;
    kbd_changed = 1;
    buttons = 0;
    sum_x = 0; sum_y = 0; sum_w = 0;
    mouse_changed = 1;
    recording = 0; playing = 0; macro_len = 0;
  endtask

  task automatic predict_report(hidce_pkg::cmd_word_t c);
    hidce_pkg::report_word_t r;
    logic [31:0] elapsed;
    logic [25:0] e;
    logic any_held;
    logic signed [31:0] dx, dy, dw;
    r = '0;
    if (c.action >= hidce_pkg::ActKeyDown && c.action <= hidce_pkg::ActPing)
      last_feed_ms = c.time_ms;
    case (c.action)
      hidce_pkg::ActTick: begin
        if (playing) begin
          elapsed = c.time_ms - start_ms;
          while (macro_pos < macro_len && {16'd0, macro_mem[macro_pos][15:0]} <= elapsed) begin
            e = macro_mem[macro_pos];
            macro_pos++;
            case (e[17:16])
              hidce_pkg::EvKeyDown: press(e[25:18]);
              hidce_pkg::EvKeyUp: lift(e[25:18]);
              hidce_pkg::EvSetMod: begin
                mods = e[25:18];
                kbd_changed = 1;
              end
              default: ;
            endcase
          end
          if (macro_pos >= macro_len) begin
            if (looping) begin
              macro_pos = 0;
              start_ms = c.time_ms;
            end else begin
              playing = 0;
            end
          end
        end
        if (c.time_ms - last_feed_ms > {16'd0, wd_timeout}) begin
          any_held = (mods != 0) || (buttons != 0);
          foreach (slots[i]) if (slots[i] != 0) any_held = 1;
          if (any_held || playing) drop_everything();
          last_feed_ms = c.time_ms;
        end
      end
      hidce_pkg::ActKeyDown: press(c.key_code);
      hidce_pkg::ActKeyUp: lift(c.key_code);
      hidce_pkg::ActSetMod: begin
        mods = c.key_code;
        kbd_changed = 1;
      end
      hidce_pkg::ActMove: begin
        sum_x = add_sat(sum_x, c.move_x);
        sum_y = add_sat(sum_y, c.move_y);
        mouse_changed = 1;
      end
      hidce_pkg::ActButton: begin
        if (c.button_press) buttons = buttons | c.key_code;
        else buttons = buttons & ~c.key_code;
        mouse_changed = 1;
      end
      hidce_pkg::ActWheel: begin
        sum_w = add_sat(sum_w, c.wheel_step);
        mouse_changed = 1;
      end
      hidce_pkg::ActRecBegin: begin
        recording = 1; looping = c.loop_playback; playing = 0;
        macro_len = 0;
      end
      hidce_pkg::ActRecEvent: begin
        if (recording && macro_len < 256) begin
          macro_mem[macro_len] = {c.key_code, c.event_kind, c.event_offset_ms};
          macro_len++;
        end
      end
      hidce_pkg::ActRecEnd: begin
        recording = 0;
        if (macro_len > 0) begin
          playing = 1; macro_pos = 0; start_ms = c.time_ms;
        end
      end
      hidce_pkg::ActCancel: drop_everything();
      hidce_pkg::ActPing: begin
        pong_saved = c.ping_value;
        pong_due = 1;
      end
      hidce_pkg::ActReport: begin
        if (pong_due) begin
          r.report_kind = hidce_pkg::RepPong;
          r.report_nonce = pong_saved;
          pong_due = 0;
        end else if (kbd_changed) begin
          r.report_kind = hidce_pkg::RepKeyboard;
          r.report_modifiers = mods;
          foreach (slots[i]) r.report_keys[8*i +: 8] = slots[i];
          kbd_changed = 0;
        end else if (mouse_changed) begin
          dx = limit127(sum_x); dy = limit127(sum_y); dw = limit127(sum_w);
          r.report_kind = hidce_pkg::RepMouse;
          r.report_buttons = buttons;
          r.report_x = dx[7:0]; r.report_y = dy[7:0]; r.report_wheel = dw[7:0];
          sum_x -= dx; sum_y -= dy; sum_w -= dw;
          if (sum_x == 0 && sum_y == 0 && sum_w == 0) mouse_changed = 0;
        end
      end
      default: ;
    endcase
    expected_reports.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("MISMATCH report %0d %s: expected %0h, got %0h",
               report_count_o, field, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hidce_pkg::report_word_t exp_r;
    if (!rst_ni) begin
      wd_timeout = 16'd2000;
      foreach (slots[i]) slots[i] = 0;
      mods = 0; buttons = 0; kbd_changed = 0; mouse_changed = 0;
      pong_due = 0; pong_saved = 0;
      sum_x = 0; sum_y = 0; sum_w = 0;
      last_feed_ms = 0; start_ms = 0;
      macro_len = 0; macro_pos = 0;
      recording = 0; looping = 0; playing = 0;
      expected_reports.delete();
      fail_count_o = 0;
      report_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) wd_timeout = cfg_wdata_i;
      if (rep_valid_i && !rep_stall_i) begin
        if (expected_reports.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("UNEXPECTED report word %h", rep_word_i);
        end else begin
          exp_r = expected_reports.pop_front();
          if (exp_r.report_kind !== rep_word_i.report_kind)
            report_mismatch("kind", exp_r.report_kind, rep_word_i.report_kind);
          if (exp_r.report_modifiers !== rep_word_i.report_modifiers)
            report_mismatch("modifiers", exp_r.report_modifiers, rep_word_i.report_modifiers);
          if (exp_r.report_keys !== rep_word_i.report_keys)
            report_mismatch("keys", exp_r.report_keys, rep_word_i.report_keys);
          if (exp_r.report_buttons !== rep_word_i.report_buttons)
            report_mismatch("buttons", exp_r.report_buttons, rep_word_i.report_buttons);
          if (exp_r.report_x !== rep_word_i.report_x)
            report_mismatch("x", exp_r.report_x, rep_word_i.report_x);
          if (exp_r.report_y !== rep_word_i.report_y)
            report_mismatch("y", exp_r.report_y, rep_word_i.report_y);
          if (exp_r.report_wheel !== rep_word_i.report_wheel)
            report_mismatch("wheel", exp_r.report_wheel, rep_word_i.report_wheel);
          if (exp_r.report_nonce !== rep_word_i.report_nonce)
            report_mismatch("nonce", exp_r.report_nonce, rep_word_i.report_nonce);
        end
        report_count_o++;
      end
      if (cmd_valid_i && !cmd_stall_i) predict_report(cmd_word_i);
      pending_o = expected_reports.size();
    end
  end
endmodule
`default_nettype wire

// ----- dv/tb_hid_input_command_engine_top.sv -----
// Testbench top for the HID command engine: clock, reset, stimulus and verdict.
// Depends on hidce_pkg, hid_input_command_engine_top and hidce_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_hid_input_command_engine_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  hidce_pkg::cmd_word_t cmd_word = '0;
  logic rep_valid;
  logic rep_stall = 1'b0;
  hidce_pkg::report_word_t rep_word;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending, report_count;

  // The receiver normally stalls on its own random pattern. Each new hold
  // request forces a long stretch of stall so that the output register fills up.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit stall_free = 1'b0;
  int words_sent = 0;

  // Time base of the stimulus. It only ever moves forward, and wraps at 2^32.
  logic [31:0] now_ms = 32'd0;

  always #6 clk = ~clk;

  hid_input_command_engine_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cmd_valid_i(cmd_valid), .cmd_stall_o(cmd_stall), .cmd_word_i(cmd_word),
    .rep_valid_o(rep_valid), .rep_stall_i(rep_stall), .rep_word_o(rep_word),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  hidce_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .cmd_valid_i(cmd_valid), .cmd_stall_i(cmd_stall), .cmd_word_i(cmd_word),
    .rep_valid_i(rep_valid), .rep_stall_i(rep_stall), .rep_word_i(rep_word),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending), .report_count_o(report_count)
  );

  // Receiver stall pattern. It changes only on the falling edge, and a long
  // hold-off counts down in this process alone.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 60;
      rep_stall <= 1'b1;
    end else if (hold_left > 0) begin
      rep_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_free) begin
      rep_stall <= 1'b0;
    end else begin
      rep_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Offers one word and waits until the engine takes it. Between words of one
  // burst valid stays high, so it is never lowered and raised in one step.
  task automatic send_word(hidce_pkg::cmd_word_t w);
    cmd_word <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic go_idle(int gap);
    cmd_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // Builds a word with every field random, then applies the action given.
  function automatic hidce_pkg::cmd_word_t rand_word(logic [3:0] act);
    hidce_pkg::cmd_word_t w;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    w = bits[$bits(hidce_pkg::cmd_word_t)-1:0];
    w.action = act;
    w.time_ms = now_ms;
    return w;
  endfunction

  // Time usually moves by a few ms; now and then it jumps past the watchdog.
  task automatic advance_time();
    case ($urandom_range(0, 19))
      0: now_ms += $urandom_range(2000, 70000);
      1, 2: now_ms += $urandom_range(100, 1500);
      default: now_ms += $urandom_range(0, 20);
    endcase
  endtask

  task automatic send_act(logic [3:0] act);
    advance_time();
    send_word(rand_word(act));
  endtask

  task automatic send_key(logic [3:0] act, logic [7:0] code);
    hidce_pkg::cmd_word_t w;
    advance_time();
    w = rand_word(act);
    w.key_code = code;
    send_word(w);
  endtask

  // Waits until every expected report has come, then lets the engine settle
  // before a register write.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A well-formed recording: begin, some events, end,
  // then ticks to play them. Content is random; codes favor small values.
  task automatic macro_sequence(int n_events);
    hidce_pkg::cmd_word_t w;
    w = rand_word(hidce_pkg::ActRecBegin);
    send_word(w);
    for (int i = 0; i < n_events; i++) begin
      now_ms += $urandom_range(0, 5);
      w = rand_word(hidce_pkg::ActRecEvent);
      w.event_offset_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                        16'($urandom_range(0, 60));
      if ($urandom_range(0, 1)) w.key_code = 8'($urandom_range(0, 9));
      send_word(w);
    end
    now_ms += $urandom_range(0, 5);
    send_word(rand_word(hidce_pkg::ActRecEnd));
    for (int i = 0; i < 6; i++) begin
      now_ms += $urandom_range(0, 25);
      send_word(rand_word(hidce_pkg::ActTick));
      if ($urandom_range(0, 1)) send_word(rand_word(hidce_pkg::ActReport));
    end
  endtask

  int unsigned pick;
  hidce_pkg::cmd_word_t w;

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: every action, field extremes and the special cases.
    send_key(hidce_pkg::ActKeyDown, 8'h00);          // usage 0 is ignored
    for (int k = 1; k <= 7; k++) send_key(hidce_pkg::ActKeyDown, k[7:0]);   // full, then slot 0
    send_key(hidce_pkg::ActKeyDown, 8'h03);          // repeat of a held key
    send_key(hidce_pkg::ActKeyUp, 8'h00);            // release of code 0 clears nothing held
    send_key(hidce_pkg::ActSetMod, 8'hFF);
    send_act(hidce_pkg::ActReport);
    w = rand_word(hidce_pkg::ActMove);
    w.move_x = 16'sh7FFF; w.move_y = 16'sh8000;
    send_word(w);
    w.action = hidce_pkg::ActWheel; w.wheel_step = 8'sh80;
    send_word(w);
    w = rand_word(hidce_pkg::ActButton); w.key_code = 8'hFF; w.button_press = 1'b1;
    send_word(w);
    repeat (3) send_act(hidce_pkg::ActReport);
    w = rand_word(hidce_pkg::ActPing); w.ping_value = 16'hFFFF;
    send_word(w);
    send_act(hidce_pkg::ActReport);
    send_word(rand_word(hidce_pkg::ActRecEnd));      // end with nothing recorded
    send_word(rand_word(hidce_pkg::ActRecEvent));    // event outside recording
    w = rand_word(4'd13);                            // unknown action codes
    send_word(w);
    w.action = 4'd15;
    send_word(w);
    send_act(hidce_pkg::ActCancel);
    send_act(hidce_pkg::ActReport);
    now_ms += 32'd5000;                              // watchdog expires on a tick
    send_key(hidce_pkg::ActKeyDown, 8'h04);
    now_ms += 32'd3000;
    send_word(rand_word(hidce_pkg::ActTick));

    // Large moves: build pending sums far beyond the 8-bit report range.
    w = rand_word(hidce_pkg::ActMove); w.move_x = 16'sh7FFF; w.move_y = 16'sh8000;
    now_ms += 32'd1;
    for (int i = 0; i < 20; i++) begin
      w.time_ms = now_ms;
      send_word(w);
    end
    send_act(hidce_pkg::ActReport);

    // Fill the event store to its capacity and beyond, then play it once.
    write_timeout(16'hFFFF);
    w = rand_word(hidce_pkg::ActRecBegin); w.loop_playback = 1'b0;
    send_word(w);
    for (int i = 0; i < 260; i++) begin
      w = rand_word(hidce_pkg::ActRecEvent);
      w.event_offset_ms = i[15:0];
      send_word(w);
    end
    send_word(rand_word(hidce_pkg::ActRecEnd));
    now_ms += 32'd300;
    send_word(rand_word(hidce_pkg::ActTick));
    send_act(hidce_pkg::ActReport);

    // Random part across several timeout settings, the extremes among them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_timeout(16'd1);
        1: write_timeout(16'd2000);
        2: write_timeout(16'($urandom_range(2, 400)));
        default: write_timeout(16'hFFFF);
      endcase
      while (words_sent < 320 + (phase + 1) * 130) begin
        // A burst of words, then usually a random gap.
        for (int b = $urandom_range(1, 12); b > 0; b--) begin
          pick = $urandom_range(0, 99);
          if (pick < 12) macro_sequence($urandom_range(1, 8));
          else if (pick < 30) send_act(hidce_pkg::ActReport);
          else if (pick < 42)
            send_key($urandom_range(0, 1) ? hidce_pkg::ActKeyDown : hidce_pkg::ActKeyUp,
                     $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom));
          else if (pick < 52) send_act(hidce_pkg::ActTick);
          else if (pick < 96) send_act(4'($urandom_range(3, 11)));
          else send_act(4'($urandom_range(13, 15)));
        end
        if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
      end
      // Pressure: the receiver holds off while words keep being offered.
      if (phase == 1) begin
        hold_req++;
        for (int i = 0; i < 8; i++) send_act(hidce_pkg::ActReport);
      end
      // And the sender pauses once until every report has come.
      if (phase == 2) begin
        stall_free = 1'b1;
        drain();
        stall_free = 1'b0;
      end
    end

    drain();
    $display("Run covered %0d command words and %0d reports: keys, mouse sums,",
             words_sent, report_count);
    $display("recording and playback, watchdog timeouts and four timeout settings.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d reports outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
